[rtl/core/tswt_pkg.sv]
`timescale 1ns / 1ps
package tswt_pkg;

    localparam int MaxSlots = 16;
    localparam int SlotW    = 4;
    localparam int CycleW   = 20;

    localparam logic [2:0] RegEnable    = 3'd0;
    localparam logic [2:0] RegSlotTotal = 3'd1;
    localparam logic [2:0] RegOwnedMask = 3'd2;
    localparam logic [2:0] RegOwnSlot   = 3'd3;
    localparam logic [2:0] RegPeriod    = 3'd4;
    localparam logic [2:0] RegActive    = 3'd5;

    localparam logic OpQuery = 1'b0;
    localparam logic OpSync  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SWEEP,
        ST_FIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic              start;
        logic [31:0]       dividend;
        logic [CycleW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [CycleW-1:0] rem;
    } div_rsp_t;

    // Slots this node owns; falls back to the single own slot, if it is in range, when the mask holds no valid slot
    function automatic logic [MaxSlots-1:0] owned_slots(
        input logic [4:0]          slot_total,
        input logic [MaxSlots-1:0] owned_mask,
        input logic [4:0]          own_slot
    );
        logic [MaxSlots-1:0] valid;
        logic [MaxSlots-1:0] res;
        valid = '0;
        res   = '0;
        if (slot_total >= 5'(MaxSlots)) begin
            valid = '1;
        end else begin
            valid = MaxSlots'((17'd1 << slot_total) - 17'd1);
        end
        if (slot_total == 5'd0) begin
            res = '0;
        end else if ((owned_mask & valid) != '0) begin
            res = owned_mask & valid;
        end else if (own_slot < slot_total) begin
            res = MaxSlots'(17'd1 << own_slot);
        end
        return res;
    endfunction

endpackage

[rtl/core/tswt_mod_unit.sv]
`timescale 1ns / 1ps
module tswt_mod_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  tswt_pkg::div_req_t req,
    output tswt_pkg::div_rsp_t rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [31:0]                 num_reg, num_next;
    logic [tswt_pkg::CycleW-1:0] den_reg, den_next;
    logic [tswt_pkg::CycleW-1:0] rem_reg, rem_next;
    logic [tswt_pkg::CycleW:0]   trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // One restoring step a cycle, dividend bits taken from the top
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[31]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = tswt_pkg::CycleW'(trial - {1'b0, den_reg});
            end else begin
                rem_next = tswt_pkg::CycleW'(trial);
            end
            num_next = {num_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/core/tdma_slot_window_timer_core.sv]
`timescale 1ns / 1ps
// TDMA slot window timer. A sync transfer (tuser high) stores the network epoch
// against local time; every transfer, sync or query, returns one result. With a
// valid, enabled schedule an item passes the bit-serial modulo unit that folds
// the synced time into the cycle length (32 restoring steps and its done strobe),
// a sweep that takes one slot per cycle to find the current slot and the nearest
// owned start, the finish state, and the hold state that loads the output register
// once that is free. A disabled or invalid schedule goes straight to the hold
// state with fallbacks. The block takes one item at a time and is ready again as
// soon as its result is loaded; the result register lets a new item in while the
// previous result still waits.
module tdma_slot_window_timer_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // local_ms[31:0], net_epoch[63:32], needed_ms[79:64], margin_ms[95:80]
    input  logic [95:0]   s_tdata,
    // opcode[0]
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // synced_ms[31:0], slot_now[35:32], in_window[36], time_left[68:37],
    // fits[69], wait_window_ms[89:70], wait_start_ms[109:90], zero[111:110]
    output logic [111:0]  m_tdata,
    // schedule_ok[0]
    output logic          m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int CW = tswt_pkg::CycleW;
    localparam int SW = tswt_pkg::SlotW;
    localparam int MS = tswt_pkg::MaxSlots;

    // configuration
    logic          enable_reg;
    logic [4:0]    slot_total_reg;
    logic [15:0]   owned_mask_reg;
    logic [4:0]    own_slot_reg;
    logic [15:0]   period_reg;
    logic [15:0]   active_reg;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    // epoch state
    logic [31:0]   epoch_base_reg, epoch_base_next;
    logic [31:0]   sync_local_reg, sync_local_next;
    logic          epoch_known_reg, epoch_known_next;

    tswt_pkg::state_t state_reg, state_next;

    logic [31:0]   synced_reg, synced_next;
    logic [15:0]   needed_reg, needed_next;
    logic [15:0]   margin_reg, margin_next;
    logic [CW-1:0] cycle_reg, cycle_next;
    logic [CW-1:0] phase_reg, phase_next;
    logic [SW-1:0] sidx_reg, sidx_next;
    logic [CW-1:0] st_reg, st_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW:0]   wait_reg, wait_next;
    logic          ok_reg, ok_next;
    logic          inwin_reg, inwin_next;
    logic [31:0]   remain_reg, remain_next;
    logic          fits_reg, fits_next;
    logic [CW-1:0] waitwin_reg, waitwin_next;
    logic [CW-1:0] waitst_reg, waitst_next;

    logic          ovalid_reg, ovalid_next;
    logic [111:0]  odata_reg, odata_next;
    logic          ouser_reg, ouser_next;

    logic [MS-1:0] mask;
    logic          sched_ok;
    logic          accept;
    logic [31:0]   synced_in;
    logic [CW:0]   cand;
    logic [CW:0]   win_end;

    tswt_pkg::div_req_t div_req;
    tswt_pkg::div_rsp_t div_rsp;

    tswt_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            slot_total_reg <= '0;
            owned_mask_reg <= '0;
            own_slot_reg   <= '0;
            period_reg     <= '0;
            active_reg     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tswt_pkg::RegEnable:    enable_reg     <= pwdata[0];
                tswt_pkg::RegSlotTotal: slot_total_reg <= pwdata[4:0];
                tswt_pkg::RegOwnedMask: owned_mask_reg <= pwdata[15:0];
                tswt_pkg::RegOwnSlot:   own_slot_reg   <= pwdata[4:0];
                tswt_pkg::RegPeriod:    period_reg     <= pwdata[15:0];
                tswt_pkg::RegActive:    active_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            tswt_pkg::RegEnable:    prdata = {31'd0, enable_reg};
            tswt_pkg::RegSlotTotal: prdata = {27'd0, slot_total_reg};
            tswt_pkg::RegOwnedMask: prdata = {16'd0, owned_mask_reg};
            tswt_pkg::RegOwnSlot:   prdata = {27'd0, own_slot_reg};
            tswt_pkg::RegPeriod:    prdata = {16'd0, period_reg};
            tswt_pkg::RegActive:    prdata = {16'd0, active_reg};
            default:                prdata = '0;
        endcase
    end

    assign mask = tswt_pkg::owned_slots(slot_total_reg, owned_mask_reg, own_slot_reg);
    assign sched_ok = enable_reg && (slot_total_reg != 5'd0) &&
                      (slot_total_reg <= 5'(MS)) && (mask != '0) &&
                      (period_reg != 16'd0) && (active_reg != 16'd0) &&
                      (active_reg <= period_reg);

    assign s_tready = (state_reg == tswt_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        if (s_tuser == tswt_pkg::OpSync) begin
            synced_in = s_tdata[63:32];
        end else if (epoch_known_reg) begin
            synced_in = epoch_base_reg + (s_tdata[31:0] - sync_local_reg);
        end else begin
            synced_in = s_tdata[31:0];
        end
    end

    assign div_req.start    = accept & sched_ok;
    assign div_req.dividend = synced_in;
    assign div_req.divisor  = cycle_next;

    // distance from the phase to the start of the slot under sweep
    always_comb begin
        if (phase_reg < st_reg) begin
            cand = {1'b0, st_reg - phase_reg};
        end else begin
            cand = {1'b0, cycle_reg} - {1'b0, phase_reg} + {1'b0, st_reg};
        end
    end
    assign win_end = {1'b0, start_reg} + {5'd0, active_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tswt_pkg::ST_IDLE;
            epoch_known_reg <= 1'b0;
            epoch_base_reg  <= '0;
            sync_local_reg  <= '0;
            ovalid_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            epoch_known_reg <= epoch_known_next;
            epoch_base_reg  <= epoch_base_next;
            sync_local_reg  <= sync_local_next;
            ovalid_reg      <= ovalid_next;
        end
        synced_reg  <= synced_next;
        needed_reg  <= needed_next;
        margin_reg  <= margin_next;
        cycle_reg   <= cycle_next;
        phase_reg   <= phase_next;
        sidx_reg    <= sidx_next;
        st_reg      <= st_next;
        slot_reg    <= slot_next;
        start_reg   <= start_next;
        wait_reg    <= wait_next;
        ok_reg      <= ok_next;
        inwin_reg   <= inwin_next;
        remain_reg  <= remain_next;
        fits_reg    <= fits_next;
        waitwin_reg <= waitwin_next;
        waitst_reg  <= waitst_next;
        odata_reg   <= odata_next;
        ouser_reg   <= ouser_next;
    end

    always_comb begin
        state_next       = state_reg;
        epoch_known_next = epoch_known_reg;
        epoch_base_next  = epoch_base_reg;
        sync_local_next  = sync_local_reg;
        synced_next      = synced_reg;
        needed_next      = needed_reg;
        margin_next      = margin_reg;
        cycle_next       = cycle_reg;
        phase_next       = phase_reg;
        sidx_next        = sidx_reg;
        st_next          = st_reg;
        slot_next        = slot_reg;
        start_next       = start_reg;
        wait_next        = wait_reg;
        ok_next          = ok_reg;
        inwin_next       = inwin_reg;
        remain_next      = remain_reg;
        fits_next        = fits_reg;
        waitwin_next     = waitwin_reg;
        waitst_next      = waitst_reg;
        ovalid_next      = ovalid_reg;
        odata_next       = odata_reg;
        ouser_next       = ouser_reg;

        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            tswt_pkg::ST_IDLE: begin
                cycle_next = CW'(CW'(slot_total_reg) * CW'(period_reg));
                if (accept) begin
                    if (s_tuser == tswt_pkg::OpSync) begin
                        epoch_base_next  = s_tdata[63:32];
                        sync_local_next  = s_tdata[31:0];
                        epoch_known_next = 1'b1;
                    end
                    synced_next = synced_in;
                    needed_next = s_tdata[79:64];
                    margin_next = s_tdata[95:80];
                    ok_next     = sched_ok;
                    if (sched_ok) begin
                        state_next = tswt_pkg::ST_MOD;
                    end else begin
                        // fallback answer
                        inwin_next   = 1'b1;
                        remain_next  = '1;
                        fits_next    = 1'b1;
                        waitwin_next = '0;
                        waitst_next  = '0;
                        slot_next    = '0;
                        state_next   = tswt_pkg::ST_HOLD;
                    end
                end
            end
            tswt_pkg::ST_MOD: begin
                sidx_next  = '0;
                st_next    = '0;
                slot_next  = '0;
                start_next = '0;
                wait_next  = {1'b0, cycle_reg};
                phase_next = div_rsp.rem;
                if (div_rsp.done) begin
                    state_next = tswt_pkg::ST_SWEEP;
                end
            end
            tswt_pkg::ST_SWEEP: begin
                if (st_reg <= phase_reg) begin
                    slot_next  = sidx_reg;
                    start_next = st_reg;
                end
                if (mask[sidx_reg] && (cand < wait_reg)) begin
                    wait_next = cand;
                end
                st_next   = st_reg + CW'(period_reg);
                sidx_next = sidx_reg + SW'(1);
                if (sidx_reg == SW'(slot_total_reg - 5'd1)) begin
                    state_next = tswt_pkg::ST_FIN;
                end
            end
            tswt_pkg::ST_FIN: begin
                inwin_next   = mask[slot_reg] && ({1'b0, phase_reg} < win_end);
                remain_next  = inwin_next ? 32'(win_end - {1'b0, phase_reg}) : 32'd0;
                fits_next    = ({1'b0, remain_next}) >=
                               (33'(needed_reg) + 33'(margin_reg));
                waitst_next  = CW'(wait_reg);
                waitwin_next = inwin_next ? '0 : CW'(wait_reg);
                state_next   = tswt_pkg::ST_HOLD;
            end
            tswt_pkg::ST_HOLD: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    ouser_next  = ok_reg;
                    odata_next  = {2'b00, waitst_reg, waitwin_reg, fits_reg, remain_reg,
                                   inwin_reg, slot_reg, synced_reg};
                    state_next  = tswt_pkg::ST_IDLE;
                end
            end
            default: state_next = tswt_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

`ifndef SYNTHESIS
    a_div_only_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == tswt_pkg::ST_MOD)
        else $error("modulo result outside its phase");
    a_window_has_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tdata[36]) |-> m_tdata[68:37] != 32'd0)
        else $error("window reported with no time left");
    a_start_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[109:90] != 20'd0)
        else $error("zero wait to next owned start");
`endif

endmodule
